>>> hdl/lpbf_pkg.sv
// ----------------------------------------------------------------------------
// lpbf_pkg
// Shared types and codes of the LED panel bit-plane frame buffer.
// ----------------------------------------------------------------------------
package lpbf_pkg;

   localparam int MAX_PLANES_DEFAULT = 8;
   localparam int PANELS_DEFAULT     = 1;
   localparam int QUEUE_DEPTH        = 2;

   localparam int KIND_W  = 3;
   localparam int COORD_W = 16;
   localparam int VALUE_W = 16;
   localparam int SUM_W   = 17;

   // Input item kinds
   localparam logic [KIND_W-1:0] KIND_DRAW = 3'd0;
   localparam logic [KIND_W-1:0] KIND_DEEP = 3'd1;
   localparam logic [KIND_W-1:0] KIND_READ = 3'd2;
   localparam logic [KIND_W-1:0] KIND_FILL = 3'd3;
   localparam logic [KIND_W-1:0] KIND_SCAN = 3'd4;

   // Classified operation handed from front to back
   typedef enum logic [2:0] {
      OP_NOP  = 3'd0,
      OP_DRAW = 3'd1,
      OP_DEEP = 3'd2,
      OP_READ = 3'd3,
      OP_FILL = 3'd4,
      OP_SCAN = 3'd5
   } op_type;

   typedef struct packed {
      logic       write;
      logic [1:0] bit_depth;
   } cfg_type;

   typedef struct packed {
      logic read_bit;
      logic serial_bit;
      logic shift_strobe;
      logic latch_pulse;
   } result_type;

endpackage

>>> hdl/led_panel_bitplane_framebuffer_core.sv
// ----------------------------------------------------------------------------
// led_panel_bitplane_framebuffer_core
// Bit-plane frame store for a chain of 16-pixel-wide LED panels.
// ----------------------------------------------------------------------------
// Flow: the front takes items into a small queue while the back works; the
//   back pops the next item only when idle and its result register is free.
// Deep pixel reduces the folded sum bit by bit, then reads and rewrites each
//   plane in use; fill writes every word of every plane in use.
// Reset: a clearing pass writes MAX_PLANES*16*PANELS words (128 at defaults)
//   to zero, one a cycle, with req_ready low; config writes are taken as ever.
// ----------------------------------------------------------------------------
module led_panel_bitplane_framebuffer_core #(
   parameter int MAX_PLANES = lpbf_pkg::MAX_PLANES_DEFAULT,
   parameter int PANELS     = lpbf_pkg::PANELS_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   // configuration write channel
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [1:0]                          csr_bit_depth,
   // item channel
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [lpbf_pkg::KIND_W-1:0]         req_kind,
   input  logic signed [lpbf_pkg::COORD_W-1:0] req_x_coord,
   input  logic signed [lpbf_pkg::COORD_W-1:0] req_y_coord,
   input  logic [lpbf_pkg::VALUE_W-1:0]        req_pixel_value,
   // result channel
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic                                rsp_read_bit,
   output logic                                rsp_serial_bit,
   output logic                                rsp_shift_strobe,
   output logic                                rsp_latch_pulse
);

   // pixel address width and the width of one queued job
   localparam int AW    = $clog2(256 * PANELS);
   localparam int JOB_W = $bits(lpbf_pkg::op_type) + AW + lpbf_pkg::VALUE_W +
                          lpbf_pkg::SUM_W;

   logic [1:0]                   bit_depth_ff;
   lpbf_pkg::cfg_type            cfg;

   logic                         clearing;
   logic                         push_valid, push_ready;
   lpbf_pkg::op_type             f_op;
   logic [AW-1:0]                f_addr;
   logic [lpbf_pkg::VALUE_W-1:0] f_value;
   logic [lpbf_pkg::SUM_W-1:0]   f_sum;
   logic [JOB_W-1:0]             push_data, pop_data;
   logic                         pop_valid, pop_ready;
   lpbf_pkg::result_type         rsp;

   // Register is always writable; software must write it only while idle (not enforced).
   assign csr_ready     = 1'b1;
   assign cfg.write     = csr_valid && csr_ready;
   assign cfg.bit_depth = bit_depth_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         bit_depth_ff <= '0;
      end else if (cfg.write) begin
         bit_depth_ff <= csr_bit_depth;
      end
   end

   // Front: fold coordinates, bounds-check draws, classify each item.
   // Hold off new items while the store is being cleared after reset.
   lpbf_front #(
      .PANELS (PANELS),
      .AW     (AW)
   ) u_front (
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_kind        (req_kind),
      .req_x_coord     (req_x_coord),
      .req_y_coord     (req_y_coord),
      .req_pixel_value (req_pixel_value),
      .hold            (clearing),
      .push_valid      (push_valid),
      .push_ready      (push_ready),
      .job_op          (f_op),
      .job_addr        (f_addr),
      .job_value       (f_value),
      .job_sum         (f_sum)
   );

   assign push_data = {f_op, f_addr, f_value, f_sum};

   // Queue decouples classification from the multi-cycle store work.
   lpbf_queue #(
      .WIDTH (JOB_W),
      .DEPTH (lpbf_pkg::QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   // Back: plane store, scan counters and the result register.
   lpbf_back #(
      .MAX_PLANES (MAX_PLANES),
      .PANELS     (PANELS),
      .AW         (AW)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_op    (lpbf_pkg::op_type'(pop_data[JOB_W-1 -: $bits(lpbf_pkg::op_type)])),
      .pop_addr  (pop_data[lpbf_pkg::VALUE_W + lpbf_pkg::SUM_W +: AW]),
      .pop_value (pop_data[lpbf_pkg::SUM_W +: lpbf_pkg::VALUE_W]),
      .pop_sum   (pop_data[lpbf_pkg::SUM_W-1:0]),
      .clearing  (clearing),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp       (rsp)
   );

   assign rsp_read_bit     = rsp.read_bit;
   assign rsp_serial_bit   = rsp.serial_bit;
   assign rsp_shift_strobe = rsp.shift_strobe;
   assign rsp_latch_pulse  = rsp.latch_pulse;

endmodule

>>> hdl/lpbf_queue.sv
// ----------------------------------------------------------------------------
// lpbf_queue
// Small first-in first-out queue between the front and the back.
// ----------------------------------------------------------------------------
module lpbf_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = lpbf_pkg::QUEUE_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   output logic             push_ready,
   input  logic [WIDTH-1:0] push_data,
   output logic             pop_valid,
   input  logic             pop_ready,
   output logic [WIDTH-1:0] pop_data
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign push_ready = (count_ff != CNT_W'(DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_data   = slot_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

>>> hdl/lpbf_front.sv
// ----------------------------------------------------------------------------
// lpbf_front
// Accepts items, folds coordinates, checks bounds and classifies the work.
// ----------------------------------------------------------------------------
module lpbf_front #(
   parameter int PANELS = lpbf_pkg::PANELS_DEFAULT,
   parameter int AW     = $clog2(256 * PANELS)
) (
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [lpbf_pkg::KIND_W-1:0]         req_kind,
   input  logic signed [lpbf_pkg::COORD_W-1:0] req_x_coord,
   input  logic signed [lpbf_pkg::COORD_W-1:0] req_y_coord,
   input  logic [lpbf_pkg::VALUE_W-1:0]        req_pixel_value,
   input  logic                                hold,
   output logic                                push_valid,
   input  logic                                push_ready,
   output lpbf_pkg::op_type                    job_op,
   output logic [AW-1:0]                       job_addr,
   output logic [lpbf_pkg::VALUE_W-1:0]        job_value,
   output logic [lpbf_pkg::SUM_W-1:0]          job_sum
);

   localparam int          PIXELS  = 256 * PANELS;
   localparam int          Y_LIMIT = 16 * PANELS;
   localparam logic [AW-1:0] PIX_MASK = AW'(PIXELS - 1);

   logic [lpbf_pkg::COORD_W-1:0] x_raw, y_raw, fx, fy;
   logic                         big, in_bounds;
   logic [AW-1:0]                lin;

   assign req_ready  = push_ready && !hold;
   assign push_valid = req_valid && !hold;
   assign job_value  = req_pixel_value;

   always_comb begin
      x_raw = req_x_coord;
      y_raw = req_y_coord;
      // deep pixels fold on the unsigned column, the others on the signed one
      if (req_kind == lpbf_pkg::KIND_DEEP) begin
         big = |x_raw[15:3];
      end else begin
         big = !x_raw[15] && (|x_raw[14:3]);
      end
      fx = big ? {13'd0, x_raw[2:0]} : x_raw;
      fy = big ? y_raw + 16'h0010 : y_raw;
      // only the low address bits survive the mask
      lin      = fx[AW-1:0] + {fy[AW-4:0], 3'b000};
      job_addr = lin & PIX_MASK;
      job_sum  = {1'b0, fx} + {1'b0, fy};
      in_bounds = !x_raw[15] && (x_raw[14:4] == '0) &&
                  !y_raw[15] && (y_raw < 16'(Y_LIMIT));
   end

   always_comb begin
      unique case (req_kind)
         lpbf_pkg::KIND_DRAW: job_op = in_bounds ? lpbf_pkg::OP_DRAW : lpbf_pkg::OP_NOP;
         lpbf_pkg::KIND_DEEP: job_op = lpbf_pkg::OP_DEEP;
         lpbf_pkg::KIND_READ: job_op = lpbf_pkg::OP_READ;
         lpbf_pkg::KIND_FILL: job_op = lpbf_pkg::OP_FILL;
         lpbf_pkg::KIND_SCAN: job_op = lpbf_pkg::OP_SCAN;
         default:             job_op = lpbf_pkg::OP_NOP;
      endcase
   end

endmodule

>>> hdl/lpbf_back.sv
// ----------------------------------------------------------------------------
// lpbf_back
// Executes classified items on the plane store and holds the result register.
// ----------------------------------------------------------------------------
module lpbf_back #(
   parameter int MAX_PLANES = lpbf_pkg::MAX_PLANES_DEFAULT,
   parameter int PANELS     = lpbf_pkg::PANELS_DEFAULT,
   parameter int AW         = $clog2(256 * PANELS)
) (
   input  logic                         clock,
   input  logic                         reset,
   input  lpbf_pkg::cfg_type            cfg,
   input  logic                         pop_valid,
   output logic                         pop_ready,
   input  lpbf_pkg::op_type             pop_op,
   input  logic [AW-1:0]                pop_addr,
   input  logic [lpbf_pkg::VALUE_W-1:0] pop_value,
   input  logic [lpbf_pkg::SUM_W-1:0]   pop_sum,
   output logic                         clearing,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output lpbf_pkg::result_type         rsp
);

   localparam int STRIDE      = 16 * PANELS;
   localparam int PIXELS      = 256 * PANELS;
   localparam int STORE_WORDS = MAX_PLANES * STRIDE;
   localparam int WW          = AW - 4;
   localparam int MW          = $clog2(STORE_WORDS);
   localparam int PW          = (MAX_PLANES > 1) ? $clog2(MAX_PLANES) : 1;
   localparam int CW          = $clog2(MAX_PLANES + 1);

   typedef enum logic [7:0] {
      ST_CLEAR  = 8'b0000_0001,
      ST_IDLE   = 8'b0000_0010,
      ST_SCAN   = 8'b0000_0100,
      ST_READ   = 8'b0000_1000,
      ST_MOD    = 8'b0001_0000,
      ST_RMW_RD = 8'b0010_0000,
      ST_RMW_WR = 8'b0100_0000,
      ST_FILL   = 8'b1000_0000
   } state_type;

   state_type                    state_ff, state_in;
   logic [MW-1:0]                clr_idx_ff, clr_idx_in;
   lpbf_pkg::op_type             job_op_ff, job_op_in;
   logic [AW-1:0]                job_addr_ff, job_addr_in;
   logic [lpbf_pkg::VALUE_W-1:0] job_value_ff, job_value_in;
   logic [lpbf_pkg::SUM_W-1:0]   job_sum_ff, job_sum_in;
   logic [4:0]                   mod_cnt_ff, mod_cnt_in;
   logic [CW-1:0]                rem_ff, rem_in;
   logic [PW-1:0]                ofs_ff, ofs_in;
   logic [PW-1:0]                plane_ff, plane_in;
   logic [MW-1:0]                base_ff, base_in;
   logic [WW-1:0]                word_ff, word_in;
   logic [PW-1:0]                active_ff, active_in;
   logic [AW-1:0]                scan_pos_ff, scan_pos_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   lpbf_pkg::result_type         rsp_ff, rsp_in;

   logic [15:0]                  mem [STORE_WORDS];
   logic [15:0]                  rd_data_ff;
   logic                         mem_re, mem_we;
   logic [MW-1:0]                mem_ra, mem_wa;
   logic [15:0]                  mem_wd;

   logic [4:0]                   pow;
   logic [CW-1:0]                planes, planes_m1;
   logic                         out_free, last_plane;
   logic [CW:0]                  rem2;
   logic [CW-1:0]                rem_red, rem_inc;
   logic [PW-1:0]                ofs_next;
   logic [15:0]                  bit_mask;
   logic                         pix_bit;
   lpbf_pkg::result_type         done_rsp;

   assign clearing  = (state_ff == ST_CLEAR);
   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign pop_ready = (state_ff == ST_IDLE) && out_free;

   // planes in use: 2^bit_depth, capped
   always_comb begin
      pow       = 5'd1 << cfg.bit_depth;
      planes    = (32'(pow) > MAX_PLANES) ? CW'(MAX_PLANES) : CW'(pow);
      planes_m1 = planes - 1'b1;
   end

   always_comb begin
      rem2       = {rem_ff, job_sum_ff[mod_cnt_ff]};
      rem_red    = (rem2 >= (CW + 1)'(planes)) ? CW'(rem2 - (CW + 1)'(planes)) : CW'(rem2);
      rem_inc    = (rem_red == planes_m1) ? '0 : rem_red + 1'b1;
      ofs_next   = (CW'(ofs_ff) == planes_m1) ? '0 : ofs_ff + 1'b1;
      last_plane = (job_op_ff == lpbf_pkg::OP_DRAW) || (CW'(plane_ff) == planes_m1);
      bit_mask   = 16'd1 << job_addr_ff[3:0];
      pix_bit    = job_value_ff[4'(ofs_ff)];
      done_rsp   = '0;
   end

   always_comb begin
      state_in     = state_ff;
      clr_idx_in   = clr_idx_ff;
      job_op_in    = job_op_ff;
      job_addr_in  = job_addr_ff;
      job_value_in = job_value_ff;
      job_sum_in   = job_sum_ff;
      mod_cnt_in   = mod_cnt_ff;
      rem_in       = rem_ff;
      ofs_in       = ofs_ff;
      plane_in     = plane_ff;
      base_in      = base_ff;
      word_in      = word_ff;
      active_in    = active_ff;
      scan_pos_in  = scan_pos_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;
      mem_re       = 1'b0;
      mem_ra       = '0;
      mem_we       = 1'b0;
      mem_wa       = '0;
      mem_wd       = '0;

      unique case (state_ff)
         ST_CLEAR: begin
            mem_we = 1'b1;
            mem_wa = clr_idx_ff;
            if (clr_idx_ff == MW'(STORE_WORDS - 1)) begin
               state_in = ST_IDLE;
            end else begin
               clr_idx_in = clr_idx_ff + 1'b1;
            end
         end

         ST_IDLE: begin
            if (pop_valid && out_free) begin
               job_op_in    = pop_op;
               job_addr_in  = pop_addr;
               job_value_in = pop_value;
               job_sum_in   = pop_sum;
               plane_in     = '0;
               base_in      = '0;
               word_in      = '0;
               ofs_in       = '0;
               unique case (pop_op)
                  lpbf_pkg::OP_SCAN: begin
                     mem_re   = 1'b1;
                     mem_ra   = MW'(active_ff) * MW'(STRIDE) + MW'(scan_pos_ff[AW-1:4]);
                     state_in = ST_SCAN;
                  end
                  lpbf_pkg::OP_READ: begin
                     mem_re   = 1'b1;
                     mem_ra   = MW'(pop_addr[AW-1:4]);
                     state_in = ST_READ;
                  end
                  lpbf_pkg::OP_DRAW: begin
                     mem_re   = 1'b1;
                     mem_ra   = MW'(pop_addr[AW-1:4]);
                     state_in = ST_RMW_WR;
                  end
                  lpbf_pkg::OP_DEEP: begin
                     mod_cnt_in = 5'(lpbf_pkg::SUM_W - 1);
                     rem_in     = '0;
                     state_in   = ST_MOD;
                  end
                  lpbf_pkg::OP_FILL: begin
                     state_in = ST_FILL;
                  end
                  default: begin
                     // unused kind or clipped draw: answer with all zeros
                     rsp_valid_in = 1'b1;
                     rsp_in       = done_rsp;
                  end
               endcase
            end
         end

         ST_SCAN: begin
            rsp_valid_in        = 1'b1;
            rsp_in              = done_rsp;
            rsp_in.serial_bit   = rd_data_ff[scan_pos_ff[3:0]];
            rsp_in.shift_strobe = 1'b1;
            if (scan_pos_ff == AW'(PIXELS - 1)) begin
               rsp_in.latch_pulse = 1'b1;
               scan_pos_in        = '0;
               if (planes != CW'(1)) begin
                  active_in = (CW'(active_ff) == planes_m1) ? '0 : active_ff + 1'b1;
               end
            end else begin
               scan_pos_in = scan_pos_ff + 1'b1;
            end
            state_in = ST_IDLE;
         end

         ST_READ: begin
            rsp_valid_in    = 1'b1;
            rsp_in          = done_rsp;
            rsp_in.read_bit = rd_data_ff[job_addr_ff[3:0]];
            state_in        = ST_IDLE;
         end

         ST_MOD: begin
            // one bit of the folded sum per cycle, remainder by plane count
            rem_in = rem_red;
            if (mod_cnt_ff == '0) begin
               ofs_in   = PW'(rem_inc);
               state_in = ST_RMW_RD;
            end else begin
               mod_cnt_in = mod_cnt_ff - 1'b1;
            end
         end

         ST_RMW_RD: begin
            mem_re   = 1'b1;
            mem_ra   = base_ff + MW'(job_addr_ff[AW-1:4]);
            state_in = ST_RMW_WR;
         end

         ST_RMW_WR: begin
            mem_we = 1'b1;
            mem_wa = base_ff + MW'(job_addr_ff[AW-1:4]);
            mem_wd = pix_bit ? (rd_data_ff | bit_mask) : (rd_data_ff & ~bit_mask);
            if (last_plane) begin
               rsp_valid_in = 1'b1;
               rsp_in       = done_rsp;
               state_in     = ST_IDLE;
            end else begin
               plane_in = plane_ff + 1'b1;
               base_in  = base_ff + MW'(STRIDE);
               ofs_in   = ofs_next;
               state_in = ST_RMW_RD;
            end
         end

         ST_FILL: begin
            mem_we = 1'b1;
            mem_wa = base_ff + MW'(word_ff);
            mem_wd = job_value_ff[4'(plane_ff)] ? 16'hFFFF : 16'h0000;
            if (word_ff == WW'(STRIDE - 1)) begin
               word_in = '0;
               if (CW'(plane_ff) == planes_m1) begin
                  rsp_valid_in = 1'b1;
                  rsp_in       = done_rsp;
                  state_in     = ST_IDLE;
               end else begin
                  plane_in = plane_ff + 1'b1;
                  base_in  = base_ff + MW'(STRIDE);
               end
            end else begin
               word_in = word_ff + 1'b1;
            end
         end

         default: begin
            state_in = ST_CLEAR;
         end
      endcase

      // a depth write restarts the plane sequence
      if (cfg.write) begin
         active_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_idx_ff   <= '0;
         active_ff    <= '0;
         scan_pos_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_idx_ff   <= clr_idx_in;
         active_ff    <= active_in;
         scan_pos_ff  <= scan_pos_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      job_op_ff    <= job_op_in;
      job_addr_ff  <= job_addr_in;
      job_value_ff <= job_value_in;
      job_sum_ff   <= job_sum_in;
      mod_cnt_ff   <= mod_cnt_in;
      rem_ff       <= rem_in;
      ofs_ff       <= ofs_in;
      plane_ff     <= plane_in;
      base_ff      <= base_in;
      word_ff      <= word_in;
      rsp_ff       <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_wa] <= mem_wd;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_re) begin
         rd_data_ff <= mem[mem_ra];
      end
   end

endmodule

>>> bench/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the LED panel bit-plane frame buffer core. A queue
// of pixel, fill and scan items feeds a handshake driver, a mirror of the
// frame store predicts every response, and a monitor compares each response
// field by field while both channels stall at random.
// ----------------------------------------------------------------------------
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   // kinds the block ignores
   localparam logic [lpbf_pkg::KIND_W-1:0] KIND_SPARE_FIRST = 3'd5;
   localparam logic [lpbf_pkg::KIND_W-1:0] KIND_SPARE_MID   = 3'd6;
   localparam logic [lpbf_pkg::KIND_W-1:0] KIND_SPARE_LAST  = 3'd7;

   localparam int PHASE_ITEMS = 236;
   localparam int PHASES      = 7;
   localparam int MAX_REPORTS = 40;

   typedef struct {
      logic [lpbf_pkg::KIND_W-1:0]         kind;
      logic signed [lpbf_pkg::COORD_W-1:0] x;
      logic signed [lpbf_pkg::COORD_W-1:0] y;
      logic [lpbf_pkg::VALUE_W-1:0]        value;
      bit                                  drain;   // hold until every response is back
   } cmd_type;

   // clock, reset and block ports; the driven ones start at known values
   logic                                clock = 1'b0;
   logic                                reset = 1'b1;
   logic                                csr_valid = 1'b0;
   logic                                csr_ready;
   logic [1:0]                          csr_bit_depth = 2'd0;
   logic                                req_valid = 1'b0;
   logic                                req_ready;
   logic [lpbf_pkg::KIND_W-1:0]         req_kind = '0;
   logic signed [lpbf_pkg::COORD_W-1:0] req_x_coord = '0;
   logic signed [lpbf_pkg::COORD_W-1:0] req_y_coord = '0;
   logic [lpbf_pkg::VALUE_W-1:0]        req_pixel_value = '0;
   logic                                rsp_valid;
   logic                                rsp_ready = 1'b0;
   logic                                rsp_read_bit;
   logic                                rsp_serial_bit;
   logic                                rsp_shift_strobe;
   logic                                rsp_latch_pulse;

   // mirror of the block's state
   bit [15:0]   mirror_store [0:127];
   int unsigned mirror_plane;
   int unsigned mirror_scan;
   bit [1:0]    mirror_depth;

   // traffic bookkeeping
   cmd_type              cmd_backlog [$];
   lpbf_pkg::result_type outputs_due [$];
   int unsigned req_issued   = 0;
   int unsigned req_accepted = 0;
   int unsigned mismatches   = 0;
   int unsigned latches_seen = 0;
   int unsigned settings_run = 0;
   int unsigned kind_seen [0:7];
   bit          calm = 1'b0;      // no stalls on either side while set

   // recently drawn pixels, so reads often reuse a recently drawn coordinate
   logic signed [lpbf_pkg::COORD_W-1:0] recent_x [0:7];
   logic signed [lpbf_pkg::COORD_W-1:0] recent_y [0:7];
   int unsigned                         recent_n = 0;

   led_panel_bitplane_framebuffer_core dut (
      .clock            (clock),
      .reset            (reset),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_bit_depth    (csr_bit_depth),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_kind         (req_kind),
      .req_x_coord      (req_x_coord),
      .req_y_coord      (req_y_coord),
      .req_pixel_value  (req_pixel_value),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_read_bit     (rsp_read_bit),
      .rsp_serial_bit   (rsp_serial_bit),
      .rsp_shift_strobe (rsp_shift_strobe),
      .rsp_latch_pulse  (rsp_latch_pulse)
   );

   always #2 clock = ~clock;

   // Fold a pixel and return its bit address within a plane. With x taken
   // as signed, a negative x never folds. Only the low 8 bits of the sum
   // survive, so sign extension has no effect on the address.
   function automatic bit [7:0] fold_address(input bit [15:0] x, input bit [15:0] y,
                                             input bit x_signed,
                                             output bit [15:0] fx, output bit [15:0] fy);
      bit big;
      big = x_signed ? (!x[15] && x > 16'd7) : (x > 16'd7);
      if (big) begin
         y = y + 16'h10;
         x = x & 16'h7;
      end
      fx = x;
      fy = y;
      return x[7:0] + {y[4:0], 3'b000};
   endfunction

   function automatic void put_pixel_bit(input int unsigned plane, input bit [7:0] addr,
                                         input bit on);
      mirror_store[plane * 16 + addr[7:4]][addr[3:0]] = on;
   endfunction

   // Apply one item to the mirror and return the response it must produce.
   function automatic lpbf_pkg::result_type emulate_panel(input cmd_type c);
      lpbf_pkg::result_type r;
      int unsigned          planes, base, ofs, plane, pos, i, j;
      bit [15:0]            fx, fy;
      bit [7:0]             addr;
      r = '0;
      planes = 1 << mirror_depth;
      case (c.kind)
         lpbf_pkg::KIND_DRAW: begin
            // clip to the panel before touching plane 0
            if (c.x >= 0 && c.y >= 0 && c.x < 16 && c.y < 16) begin
               addr = fold_address(c.x, c.y, 1'b1, fx, fy);
               put_pixel_bit(0, addr, c.value[0]);
            end
         end
         lpbf_pkg::KIND_DEEP: begin
            // no clipping; plane i takes a rotated bit of the value
            addr = fold_address(c.x, c.y, 1'b0, fx, fy);
            base = (fx + fy) % planes;
            for (i = 0; i < planes; i++) begin
               ofs = (base + 1 + i) % planes;
               put_pixel_bit(i, addr, c.value[ofs]);
            end
         end
         lpbf_pkg::KIND_READ: begin
            addr = fold_address(c.x, c.y, 1'b1, fx, fy);
            r.read_bit = mirror_store[addr[7:4]][addr[3:0]];
         end
         lpbf_pkg::KIND_FILL: begin
            for (i = 0; i < planes; i++)
               for (j = 0; j < 16; j++)
                  mirror_store[i * 16 + j] = c.value[i] ? 16'hFFFF : 16'h0000;
         end
         lpbf_pkg::KIND_SCAN: begin
            // a single plane always scans plane 0 and never advances
            plane = (planes == 1) ? 0 : mirror_plane % planes;
            pos = mirror_scan % 256;
            r.serial_bit   = mirror_store[plane * 16 + pos / 16][pos % 16];
            r.shift_strobe = 1'b1;
            if (pos == 255) begin
               r.latch_pulse = 1'b1;
               mirror_scan = 0;
               if (planes != 1)
                  mirror_plane = (plane + 1) % planes;
            end else begin
               mirror_scan = pos + 1;
            end
         end
         default: begin
         end
      endcase
      return r;
   endfunction

   // Mostly on-panel coordinates, some edge values, some anything at all.
   function automatic logic signed [lpbf_pkg::COORD_W-1:0] pick_coord();
      int unsigned r;
      r = $urandom_range(99);
      if (r < 70)
         return 16'($urandom_range(15));
      if (r < 85) begin
         case ($urandom_range(5))
            0: return -16'sd1;
            1: return 16'sd16;
            2: return -16'sd32768;
            3: return 16'sd32767;
            4: return 16'sd15;
            default: return 16'sd0;
         endcase
      end
      return 16'($urandom);
   endfunction

   // Scan-heavy mix so latches and plane advances keep coming.
   function automatic cmd_type random_cmd();
      cmd_type     c;
      int unsigned r, k;
      r = $urandom_range(99);
      if (r < 55)
         c.kind = lpbf_pkg::KIND_SCAN;
      else if (r < 70)
         c.kind = lpbf_pkg::KIND_DRAW;
      else if (r < 82)
         c.kind = lpbf_pkg::KIND_READ;
      else if (r < 93)
         c.kind = lpbf_pkg::KIND_DEEP;
      else if (r < 96)
         c.kind = lpbf_pkg::KIND_FILL;
      else
         c.kind = 3'($urandom_range(KIND_SPARE_LAST, KIND_SPARE_FIRST));
      c.x = pick_coord();
      c.y = pick_coord();
      c.value = 16'($urandom);
      c.drain = ($urandom_range(99) == 0);
      if (c.kind == lpbf_pkg::KIND_READ && recent_n != 0 && $urandom_range(1)) begin
         k = $urandom_range(recent_n > 8 ? 7 : recent_n - 1);
         c.x = recent_x[k];
         c.y = recent_y[k];
      end
      if (c.kind == lpbf_pkg::KIND_DRAW) begin
         recent_x[recent_n % 8] = c.x;
         recent_y[recent_n % 8] = c.y;
         recent_n++;
      end
      return c;
   endfunction

   function automatic void queue_cmd(input logic [lpbf_pkg::KIND_W-1:0] kind,
                                     input logic signed [lpbf_pkg::COORD_W-1:0] x,
                                     input logic signed [lpbf_pkg::COORD_W-1:0] y,
                                     input logic [lpbf_pkg::VALUE_W-1:0] value,
                                     input bit drain);
      cmd_type c;
      c.kind  = kind;
      c.x     = x;
      c.y     = y;
      c.value = value;
      c.drain = drain;
      cmd_backlog.push_back(c);
   endfunction

   function automatic bit bool_idle();
      return cmd_backlog.size() == 0 && req_accepted == req_issued &&
             outputs_due.size() == 0;
   endfunction

   // Wait until every item is in and every response is out, then let the pipeline settle.
   task automatic wait_idle(input int unsigned tail);
      while (!bool_idle())
         @(posedge clock);
      repeat (tail) @(posedge clock);
   endtask

   task automatic write_bit_depth(input logic [1:0] depth);
      @(negedge clock);
      csr_bit_depth <= depth;
      csr_valid     <= 1'b1;
      do
         @(posedge clock);
      while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
      settings_run++;
   endtask

   task automatic check_field(input string name, input bit expected_bit, input logic actual);
      if (actual !== expected_bit) begin
         mismatches++;
         if (mismatches <= MAX_REPORTS)
            $display("%0t: %s mismatch, expected %0b actual %b", $time, name,
                     expected_bit, actual);
      end
   endtask

   // ---------------------------------------------------------------------
   // Request driver: present the next item at the falling edge once the
   // previous one is accepted; hold valid and payload until then.
   // ---------------------------------------------------------------------
   always @(negedge clock) begin : drive_req
      cmd_type c;
      if (!reset && req_accepted == req_issued) begin
         // a drain item waits for every response already owed
         if (cmd_backlog.size() != 0 && (calm || $urandom_range(99) >= 26) &&
             (!cmd_backlog[0].drain || outputs_due.size() == 0)) begin
            c = cmd_backlog.pop_front();
            req_kind        <= c.kind;
            req_x_coord     <= c.x;
            req_y_coord     <= c.y;
            req_pixel_value <= c.value;
            req_valid       <= 1'b1;
            req_issued++;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Track accepted items and config writes; predict at the same edge the
   // block takes them.
   always @(posedge clock) begin : predict_req
      cmd_type c;
      if (csr_valid && csr_ready) begin
         mirror_depth = csr_bit_depth;
         mirror_plane = 0;    // a new depth restarts at plane 0, scan kept
      end
      if (req_valid && req_ready) begin
         c.kind  = req_kind;
         c.x     = req_x_coord;
         c.y     = req_y_coord;
         c.value = req_pixel_value;
         c.drain = 1'b0;
         outputs_due.push_back(emulate_panel(c));
         kind_seen[c.kind]++;
         req_accepted++;
      end
   end

   // ---------------------------------------------------------------------
   // Response monitor: stall at random, compare each accepted response with
   // the oldest prediction.
   // ---------------------------------------------------------------------
   always @(negedge clock) begin
      rsp_ready <= !reset && (calm || $urandom_range(99) >= 26);
   end

   always @(posedge clock) begin : watch_rsp
      lpbf_pkg::result_type due;
      if (!reset && rsp_valid && rsp_ready) begin
         if (outputs_due.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
               $display("%0t: response with nothing awaited, expected none actual %b%b%b%b",
                        $time, rsp_read_bit, rsp_serial_bit, rsp_shift_strobe,
                        rsp_latch_pulse);
         end else begin
            due = outputs_due.pop_front();
            check_field("read_bit",     due.read_bit,     rsp_read_bit);
            check_field("serial_bit",   due.serial_bit,   rsp_serial_bit);
            check_field("shift_strobe", due.shift_strobe, rsp_shift_strobe);
            check_field("latch_pulse",  due.latch_pulse,  rsp_latch_pulse);
            if (due.latch_pulse)
               latches_seen++;
         end
      end
   end

   // Watchdog: far beyond the slowest legal run.
   initial begin
      #4_000_000;
      $display("FAILED: results differ");
      $finish;
   end

   // ---------------------------------------------------------------------
   // Sequencer: reset, then one phase per bit_depth setting. Depth is only
   // rewritten once the block has drained.
   // ---------------------------------------------------------------------
   initial begin : sequencer
      logic [1:0]  depth_plan [0:PHASES-1];
      int unsigned p, n;
      depth_plan = '{2'd0, 2'd2, 2'd1, 2'd3, 2'd0, 2'd3, 2'd1};
      for (n = 0; n < 128; n++)
         mirror_store[n] = '0;
      for (n = 0; n < 8; n++)
         kind_seen[n] = 0;
      mirror_plane = 0;
      mirror_scan  = 0;
      mirror_depth = 2'd0;

      // hold reset, then release it at a falling edge
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (p = 0; p < PHASES; p++) begin
         wait_idle(6);
         write_bit_depth(depth_plan[p]);
         // one stretch with no stalls at all
         calm = (p == 3);
         if (p == 0) begin
            // directed: fill, clipped draws, folds, wraps, spare kinds
            queue_cmd(lpbf_pkg::KIND_FILL, 16'sd0, 16'sd0, 16'hFFFF, 1'b0);
            queue_cmd(lpbf_pkg::KIND_SCAN, 16'sd0, 16'sd0, 16'h0000, 1'b0);
            queue_cmd(lpbf_pkg::KIND_DRAW, 16'sd0, 16'sd0, 16'h0000, 1'b0);
            queue_cmd(lpbf_pkg::KIND_READ, 16'sd0, 16'sd0, 16'h0000, 1'b0);
            queue_cmd(lpbf_pkg::KIND_DRAW, 16'sd15, 16'sd15, 16'hFFFE, 1'b0);
            queue_cmd(lpbf_pkg::KIND_READ, 16'sd15, 16'sd15, 16'h0000, 1'b0);
            queue_cmd(lpbf_pkg::KIND_DRAW, -16'sd1, 16'sd0, 16'h0000, 1'b0);
            queue_cmd(lpbf_pkg::KIND_DRAW, 16'sd16, 16'sd0, 16'h0000, 1'b0);
            queue_cmd(lpbf_pkg::KIND_DRAW, 16'sd0, 16'sd16, 16'h0000, 1'b0);
            queue_cmd(lpbf_pkg::KIND_DRAW, 16'sd0, -16'sd1, 16'h0000, 1'b0);
            queue_cmd(lpbf_pkg::KIND_DRAW, -16'sd32768, 16'sd32767, 16'h0000, 1'b0);
            queue_cmd(lpbf_pkg::KIND_READ, -16'sd1, 16'sd0, 16'h0000, 1'b1);
            queue_cmd(lpbf_pkg::KIND_READ, 16'sd32767, -16'sd32768, 16'h0000, 1'b0);
            queue_cmd(lpbf_pkg::KIND_READ, 16'sd16, 16'sd0, 16'h0000, 1'b0);
            queue_cmd(lpbf_pkg::KIND_DEEP, -16'sd1, -16'sd1, 16'hFFFF, 1'b0);
            queue_cmd(lpbf_pkg::KIND_DEEP, 16'sd8, 16'sd0, 16'h5554, 1'b0);
            queue_cmd(lpbf_pkg::KIND_READ, 16'sd8, 16'sd0, 16'h0000, 1'b0);
            queue_cmd(lpbf_pkg::KIND_FILL, 16'sd0, 16'sd0, 16'h0000, 1'b0);
            queue_cmd(KIND_SPARE_FIRST, -16'sd1, -16'sd1, 16'hFFFF, 1'b0);
            queue_cmd(KIND_SPARE_MID, 16'sd0, 16'sd0, 16'h0000, 1'b0);
            queue_cmd(KIND_SPARE_LAST, 16'sd32767, -16'sd32768, 16'h8000, 1'b0);
            queue_cmd(lpbf_pkg::KIND_DRAW, 16'sd7, 16'sd8, 16'h0001, 1'b0);
            queue_cmd(lpbf_pkg::KIND_READ, 16'sd7, 16'sd8, 16'h0000, 1'b0);
            queue_cmd(lpbf_pkg::KIND_SCAN, 16'sd0, 16'sd0, 16'h0000, 1'b0);
            queue_cmd(lpbf_pkg::KIND_SCAN, -16'sd1, -16'sd1, 16'hFFFF, 1'b0);
         end
         for (n = 0; n < PHASE_ITEMS; n++)
            cmd_backlog.push_back(random_cmd());
      end

      // drain, then give a stray response time to show up
      wait_idle(12);
      $display("Covered %0d items: draw %0d, deep %0d, read %0d, fill %0d, scan %0d, spare %0d",
               req_accepted, kind_seen[lpbf_pkg::KIND_DRAW], kind_seen[lpbf_pkg::KIND_DEEP],
               kind_seen[lpbf_pkg::KIND_READ], kind_seen[lpbf_pkg::KIND_FILL],
               kind_seen[lpbf_pkg::KIND_SCAN],
               kind_seen[KIND_SPARE_FIRST] + kind_seen[KIND_SPARE_MID] +
               kind_seen[KIND_SPARE_LAST]);
      $display("Across %0d bit_depth writes: %0d latch pulses, %0d mismatches",
               settings_run, latches_seen, mismatches);
      if (mismatches == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

endmodule

>>> led_panel_bitplane_framebuffer_core.f
hdl/lpbf_pkg.sv
hdl/lpbf_queue.sv
hdl/lpbf_front.sv
hdl/lpbf_back.sv
hdl/led_panel_bitplane_framebuffer_core.sv
bench/testbench.sv
